// File: rtl/move_to_target_motion_profile_unit_defines.svh
// assertion macros for the move-to-target motion profile unit
`ifndef MOVE_TO_TARGET_MOTION_PROFILE_UNIT_DEFINES_SVH
`define MOVE_TO_TARGET_MOTION_PROFILE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MTT_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define MTT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mtt_pkg.sv
// shared constants and codes for the move-to-target motion profile unit
`timescale 1ns / 1ps
`default_nettype none
package mtt_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int SPEED_W        = 32;
    localparam int TS_W           = 16;
    localparam int TS_FRAC        = 16;
    localparam int CFG_ADDR_W     = 2;

    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_SET_TARGET = 2'd1,
        CMD_PLACE      = 2'd2,
        CMD_SET_RUN    = 2'd3
    } cmd_t;

    localparam logic [CFG_ADDR_W-1:0] REG_MAX_SPEED = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEL     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DECEL     = 2'd2;

endpackage
`default_nettype wire

// File: rtl/move_to_target_motion_profile_unit.sv
// move-to-target motion profile unit: 3d point with trapezoidal speed profile
//
// input channel s_*: one command per transfer (tick, set target, place, set running)
// result channel m_*: exactly one result transfer per command, in command order
// config port: cfg_wr_en/cfg_addr/cfg_wr_data write max_speed (0), acceleration (1)
//   and deceleration (2); other indexes are ignored
// set target, place, set running and a tick while stopped go from the input transfer
//   to the done state and from there into the output register
// a running tick goes through one shared bit-serial multiplier, one bit-serial square
//   root and one restoring divider: it normalizes the axis distances, squares and sums
//   them, takes the root and shifts it back, snaps onto the target when close, else
//   runs the braking product and root (with deceleration only), the speed ramp (with
//   acceleration only), the travel product and, per axis, a multiply and a divide
// one command is in work at a time; s_ready is high only while no command is in work
// the result sits in an output register, so a new command is taken while a
//   finished result still waits for m_ready
// a stalled receiver holds the finished next result in the sequencer until the
//   output register frees up
// reset (aresetn low, synchronous) zeroes position, target, speed and running flag,
//   sets max_speed to 1.0 and clears acceleration and deceleration
`timescale 1ns / 1ps
`default_nettype none
`include "move_to_target_motion_profile_unit_defines.svh"
module move_to_target_motion_profile_unit
    import mtt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [1:0]                   s_cmd,
    input  wire  signed [COORD_BITS-1:0] s_coord_x,
    input  wire  signed [COORD_BITS-1:0] s_coord_y,
    input  wire  signed [COORD_BITS-1:0] s_coord_z,
    input  wire  [TS_W-1:0]              s_time_step,
    input  wire                          s_run_flag,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic signed [COORD_BITS-1:0] m_pos_x,
    output logic signed [COORD_BITS-1:0] m_pos_y,
    output logic signed [COORD_BITS-1:0] m_pos_z,
    output logic [SPEED_W-1:0]           m_speed_now,
    output logic                         m_moving,
    output logic                         m_reached_end,
    input  wire                          cfg_wr_en,
    input  wire  [CFG_ADDR_W-1:0]        cfg_addr,
    input  wire  [SPEED_W-1:0]           cfg_wr_data
);

    localparam int CW    = COORD_BITS;
    localparam int LW    = COORD_BITS + 1;          // distance width
    localparam int MBW   = SPEED_W + 1;             // multiplier operand, one bit per cycle
    localparam int PRW   = LW + MBW;                // product / dividend width
    localparam int CNTW  = $clog2(PRW + 1);
    localparam int SHW   = $clog2(COORD_BITS + 1);
    localparam int CMPW  = (LW > SPEED_W) ? LW : SPEED_W;
    localparam int RTW   = 64;                      // square root radicand width
    localparam longint unsigned EPS_SET  = ((longint'(1) << FRAC_BITS) + 500) / 1000;
    localparam longint unsigned EPS_SNAP = ((longint'(2) << FRAC_BITS) + 500) / 1000;

    typedef enum logic [14:0] {
        ST_IDLE   = 15'b000000000000001,
        ST_NORM   = 15'b000000000000010,
        ST_SQR    = 15'b000000000000100,
        ST_ROOT   = 15'b000000000001000,
        ST_SHL    = 15'b000000000010000,
        ST_BRMUL  = 15'b000000000100000,
        ST_BRROOT = 15'b000000001000000,
        ST_SPEED  = 15'b000000010000000,
        ST_RAMP   = 15'b000000100000000,
        ST_TRAV   = 15'b000001000000000,
        ST_TRMUL  = 15'b000010000000000,
        ST_STEP   = 15'b000100000000000,
        ST_STMUL  = 15'b001000000000000,
        ST_STDIV  = 15'b010000000000000,
        ST_DONE   = 15'b100000000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic                   running_reg, running_next;
    logic [SPEED_W-1:0]     cur_speed_reg, cur_speed_next;
    logic [SPEED_W-1:0]     max_speed_reg, max_speed_next;
    logic [SPEED_W-1:0]     accel_reg, accel_next;
    logic [SPEED_W-1:0]     decel_reg, decel_next;
    logic signed [CW-1:0]   pos_reg [3];
    logic signed [CW-1:0]   pos_next [3];
    logic signed [CW-1:0]   tgt_reg [3];
    logic signed [CW-1:0]   tgt_next [3];
    logic [CW-1:0]          mag_reg [3];
    logic [CW-1:0]          mag_next [3];
    logic [CW-1:0]          nm_reg [3];
    logic [CW-1:0]          nm_next [3];
    logic [2:0]             neg_reg, neg_next;
    logic [SHW-1:0]         shift_reg, shift_next;
    logic [1:0]             axis_reg, axis_next;
    logic [TS_W-1:0]        ts_reg, ts_next;
    logic [PRW-1:0]         ma_reg, ma_next;
    logic [MBW-1:0]         mb_reg, mb_next;
    logic [PRW-1:0]         acc_reg, acc_next;
    logic [CNTW-1:0]        cnt_reg, cnt_next;
    logic [RTW-1:0]         rn_reg, rn_next;
    logic [RTW-1:0]         rres_reg, rres_next;
    logic [RTW-1:0]         rbit_reg, rbit_next;
    logic [LW-1:0]          len_reg, len_next;
    logic [SPEED_W-1:0]     lim_reg, lim_next;
    logic [SPEED_W-1:0]     trav_reg, trav_next;
    logic [LW-1:0]          rem_reg, rem_next;
    logic                   reached_reg, reached_next;
    logic                   m_valid_reg, m_valid_next;
    logic signed [CW-1:0]   out_pos_reg [3];
    logic signed [CW-1:0]   out_pos_next [3];
    logic [SPEED_W-1:0]     out_speed_reg, out_speed_next;
    logic                   out_moving_reg, out_moving_next;
    logic                   out_reached_reg, out_reached_next;

    // datapath helpers
    logic signed [CW-1:0]   coord_in [3];
    logic signed [CW:0]     tdiff [3];
    logic signed [CW:0]     sdiff [3];
    logic [CW:0]            tmag [3];
    logic [CW:0]            smag [3];
    logic                   differs;
    logic                   need_norm;
    logic [PRW-1:0]         mul_acc;
    logic                   mul_last;
    logic [RTW-1:0]         rt_try;
    logic                   rt_ge;
    logic [RTW-1:0]         rt_res;
    logic [LW:0]            div_sh;
    logic                   div_ge;
    logic [PRW-1:0]         div_q;
    logic [CW-1:0]          step_q;
    logic [SPEED_W+1:0]     spd_new;
    logic [SPEED_W-1:0]     trav_raw;
    logic [SPEED_W-1:0]     brake;

    assign coord_in[0] = s_coord_x;
    assign coord_in[1] = s_coord_y;
    assign coord_in[2] = s_coord_z;

    // distances at the input transfer
    always_comb begin
        differs = 1'b0;
        for (int i = 0; i < 3; i++) begin
            tdiff[i] = {tgt_reg[i][CW-1], tgt_reg[i]} - {pos_reg[i][CW-1], pos_reg[i]};
            sdiff[i] = {tgt_reg[i][CW-1], tgt_reg[i]} - {coord_in[i][CW-1], coord_in[i]};
            tmag[i]  = tdiff[i][CW] ? (CW+1)'(-tdiff[i]) : (CW+1)'(tdiff[i]);
            smag[i]  = sdiff[i][CW] ? (CW+1)'(-sdiff[i]) : (CW+1)'(sdiff[i]);
            if (64'(smag[i]) > EPS_SET) begin
                differs = 1'b1;
            end
        end
        need_norm = ((nm_reg[0] >> 31) != '0) || ((nm_reg[1] >> 31) != '0) ||
                    ((nm_reg[2] >> 31) != '0);
    end

    // shared bit-serial multiply, square root and divide steps
    always_comb begin
        mul_acc  = mb_reg[0] ? acc_reg + ma_reg : acc_reg;
        mul_last = (cnt_reg == CNTW'(1));
        rt_try   = rres_reg + rbit_reg;
        rt_ge    = (rn_reg >= rt_try);
        rt_res   = rt_ge ? (rres_reg >> 1) + rbit_reg : (rres_reg >> 1);
        div_sh   = {rem_reg, acc_reg[PRW-1]};
        div_ge   = (div_sh >= (LW+1)'(len_reg));
        div_q    = {acc_reg[PRW-2:0], div_ge};
        step_q   = CW'(div_q);
        spd_new  = (SPEED_W+2)'(cur_speed_reg) + (SPEED_W+2)'(mul_acc >> TS_FRAC);
        trav_raw = SPEED_W'(mul_acc >> TS_FRAC);
        brake    = SPEED_W'(rt_res);
    end

    always_comb begin
        state_next       = state_reg;
        running_next     = running_reg;
        cur_speed_next   = cur_speed_reg;
        max_speed_next   = max_speed_reg;
        accel_next       = accel_reg;
        decel_next       = decel_reg;
        pos_next         = pos_reg;
        tgt_next         = tgt_reg;
        mag_next         = mag_reg;
        nm_next          = nm_reg;
        neg_next         = neg_reg;
        shift_next       = shift_reg;
        axis_next        = axis_reg;
        ts_next          = ts_reg;
        ma_next          = ma_reg;
        mb_next          = mb_reg;
        acc_next         = acc_reg;
        cnt_next         = cnt_reg;
        rn_next          = rn_reg;
        rres_next        = rres_reg;
        rbit_next        = rbit_reg;
        len_next         = len_reg;
        lim_next         = lim_reg;
        trav_next        = trav_reg;
        rem_next         = rem_reg;
        reached_next     = reached_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        out_pos_next     = out_pos_reg;
        out_speed_next   = out_speed_reg;
        out_moving_next  = out_moving_reg;
        out_reached_next = out_reached_reg;

        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MAX_SPEED: max_speed_next = cfg_wr_data;
                REG_ACCEL:     accel_next = cfg_wr_data;
                REG_DECEL:     decel_next = cfg_wr_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ts_next      = s_time_step;
                    reached_next = 1'b0;
                    state_next   = ST_DONE;
                    case (cmd_t'(s_cmd))
                        CMD_TICK: begin
                            if (running_reg) begin
                                for (int i = 0; i < 3; i++) begin
                                    mag_next[i] = CW'(tmag[i]);
                                    nm_next[i]  = CW'(tmag[i]);
                                    neg_next[i] = tdiff[i][CW];
                                end
                                shift_next = '0;
                                state_next = ST_NORM;
                            end
                        end
                        CMD_SET_TARGET: begin
                            if (differs) begin
                                tgt_next     = coord_in;
                                running_next = 1'b1;
                            end
                        end
                        CMD_PLACE: begin
                            tgt_next     = coord_in;
                            pos_next     = coord_in;
                            running_next = 1'b0;
                        end
                        CMD_SET_RUN: running_next = s_run_flag;
                        default: ;
                    endcase
                end
            end
            ST_NORM: begin
                if (need_norm) begin
                    for (int i = 0; i < 3; i++) begin
                        nm_next[i] = nm_reg[i] >> 1;
                    end
                    shift_next = shift_reg + SHW'(1);
                end else begin
                    axis_next  = '0;
                    acc_next   = '0;
                    ma_next    = PRW'(nm_reg[0]);
                    mb_next    = MBW'(nm_reg[0]);
                    cnt_next   = CNTW'(MBW);
                    state_next = ST_SQR;
                end
            end
            ST_SQR, ST_BRMUL, ST_RAMP, ST_TRMUL, ST_STMUL: begin
                acc_next = mul_acc;
                ma_next  = ma_reg << 1;
                mb_next  = mb_reg >> 1;
                cnt_next = cnt_reg - CNTW'(1);
                if (mul_last) begin
                    case (state_reg)
                        ST_SQR: begin
                            if (axis_reg == 2'd2) begin
                                rn_next    = RTW'(mul_acc);
                                rres_next  = '0;
                                rbit_next  = RTW'(1) << (RTW - 2);
                                state_next = ST_ROOT;
                            end else begin
                                axis_next = axis_reg + 2'd1;
                                ma_next   = PRW'(nm_reg[axis_reg + 2'd1]);
                                mb_next   = MBW'(nm_reg[axis_reg + 2'd1]);
                                cnt_next  = CNTW'(MBW);
                            end
                        end
                        ST_BRMUL: begin
                            // product beyond 64 bits saturates
                            rn_next    = ((mul_acc >> RTW) != '0) ? '1 : RTW'(mul_acc);
                            rres_next  = '0;
                            rbit_next  = RTW'(1) << (RTW - 2);
                            state_next = ST_BRROOT;
                        end
                        ST_RAMP: begin
                            cur_speed_next = (spd_new > (SPEED_W+2)'(lim_reg)) ?
                                             lim_reg : SPEED_W'(spd_new);
                            state_next     = ST_TRAV;
                        end
                        ST_TRMUL: begin
                            trav_next  = (CMPW'(trav_raw) > CMPW'(len_reg)) ?
                                         SPEED_W'(len_reg) : trav_raw;
                            axis_next  = '0;
                            state_next = ST_STEP;
                        end
                        default: begin
                            rem_next   = '0;
                            cnt_next   = CNTW'(PRW);
                            state_next = ST_STDIV;
                        end
                    endcase
                end
            end
            ST_ROOT, ST_BRROOT: begin
                rres_next = rt_res;
                rbit_next = rbit_reg >> 2;
                if (rt_ge) begin
                    rn_next = rn_reg - rt_try;
                end
                if (rbit_reg[0]) begin
                    if (state_reg == ST_ROOT) begin
                        len_next   = LW'(rt_res);
                        state_next = ST_SHL;
                    end else begin
                        lim_next   = (brake < max_speed_reg) ? brake : max_speed_reg;
                        state_next = ST_SPEED;
                    end
                end
            end
            ST_SHL: begin
                if (shift_reg != '0) begin
                    len_next   = len_reg << 1;
                    shift_next = shift_reg - SHW'(1);
                end else if (64'(len_reg) <= EPS_SNAP) begin
                    // close enough: snap onto the target
                    pos_next     = tgt_reg;
                    running_next = 1'b0;
                    reached_next = 1'b1;
                    state_next   = ST_DONE;
                end else if (decel_reg != '0) begin
                    ma_next    = PRW'(len_reg);
                    mb_next    = {decel_reg, 1'b0};
                    acc_next   = '0;
                    cnt_next   = CNTW'(MBW);
                    state_next = ST_BRMUL;
                end else begin
                    lim_next   = max_speed_reg;
                    state_next = ST_SPEED;
                end
            end
            ST_SPEED: begin
                if (accel_reg != '0) begin
                    ma_next    = PRW'(accel_reg);
                    mb_next    = MBW'(ts_reg);
                    acc_next   = '0;
                    cnt_next   = CNTW'(MBW);
                    state_next = ST_RAMP;
                end else begin
                    cur_speed_next = lim_reg;
                    state_next     = ST_TRAV;
                end
            end
            ST_TRAV: begin
                ma_next    = PRW'(cur_speed_reg);
                mb_next    = MBW'(ts_reg);
                acc_next   = '0;
                cnt_next   = CNTW'(MBW);
                state_next = ST_TRMUL;
            end
            ST_STEP: begin
                ma_next    = PRW'(mag_reg[axis_reg]);
                mb_next    = MBW'(trav_reg);
                acc_next   = '0;
                cnt_next   = CNTW'(MBW);
                state_next = ST_STMUL;
            end
            ST_STDIV: begin
                rem_next = div_ge ? LW'(div_sh - (LW+1)'(len_reg)) : LW'(div_sh);
                acc_next = div_q;
                cnt_next = cnt_reg - CNTW'(1);
                if (mul_last) begin
                    pos_next[axis_reg] = neg_reg[axis_reg] ? pos_reg[axis_reg] - step_q :
                                         pos_reg[axis_reg] + step_q;
                    if (axis_reg == 2'd2) begin
                        state_next = ST_DONE;
                    end else begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_STEP;
                    end
                end
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    out_pos_next     = pos_reg;
                    out_speed_next   = cur_speed_reg;
                    out_moving_next  = running_reg;
                    out_reached_next = reached_reg;
                    m_valid_next     = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            running_reg   <= 1'b0;
            cur_speed_reg <= '0;
            max_speed_reg <= SPEED_W'(1) << FRAC_BITS;
            accel_reg     <= '0;
            decel_reg     <= '0;
            pos_reg       <= '{default: '0};
            tgt_reg       <= '{default: '0};
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            cur_speed_reg <= cur_speed_next;
            max_speed_reg <= max_speed_next;
            accel_reg     <= accel_next;
            decel_reg     <= decel_next;
            pos_reg       <= pos_next;
            tgt_reg       <= tgt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        mag_reg         <= mag_next;
        nm_reg          <= nm_next;
        neg_reg         <= neg_next;
        shift_reg       <= shift_next;
        axis_reg        <= axis_next;
        ts_reg          <= ts_next;
        ma_reg          <= ma_next;
        mb_reg          <= mb_next;
        acc_reg         <= acc_next;
        cnt_reg         <= cnt_next;
        rn_reg          <= rn_next;
        rres_reg        <= rres_next;
        rbit_reg        <= rbit_next;
        len_reg         <= len_next;
        lim_reg         <= lim_next;
        trav_reg        <= trav_next;
        rem_reg         <= rem_next;
        reached_reg     <= reached_next;
        out_pos_reg     <= out_pos_next;
        out_speed_reg   <= out_speed_next;
        out_moving_reg  <= out_moving_next;
        out_reached_reg <= out_reached_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_pos_x       = out_pos_reg[0];
    assign m_pos_y       = out_pos_reg[1];
    assign m_pos_z       = out_pos_reg[2];
    assign m_speed_now   = out_speed_reg;
    assign m_moving      = out_moving_reg;
    assign m_reached_end = out_reached_reg;

    // a snapped result always reports the point as stopped
    `MTT_ASSERT_SAME(a_reached_stops, aclk, aresetn, m_valid && m_reached_end, !m_moving, "reached_end with moving set")
    // one command in work at a time
    `MTT_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_valid && s_ready, !s_ready, "ready right after a transfer")
    // finished result only leaves the sequencer into a free output register
    `MTT_ASSERT_NEXT(a_done_waits, aclk, aresetn, (state_reg == ST_DONE) && m_valid && !m_ready, state_reg == ST_DONE, "result dropped while output stalled")

endmodule
`default_nettype wire
